// ----- design/kdlr_pkg.sv -----
// shared constants, types and codes of the key debounce block
package kdlr_pkg;

  localparam int NUM_KEYS     = 3;
  localparam int FILTER_TICKS = 5;
  localparam int FIFO_DEPTH   = 16;
  localparam int CFG_KEYS     = 3;

  localparam int FILT_HI    = 2 * FILTER_TICKS;
  localparam int FILT_W     = $clog2(FILT_HI + 1);
  localparam int FILT_RESET = FILTER_TICKS / 2;

  localparam int LT_W     = 16;
  localparam int RS_W     = 8;
  localparam int LT_RESET = 100;
  localparam int CODE_W   = 5;
  localparam int ACT_W    = 2;

  localparam int CFG_IDX_W       = $clog2(2 * CFG_KEYS);
  localparam int CFG_DATA_W      = LT_W;
  localparam int CFG_LONG_BASE   = 0;
  localparam int CFG_REPEAT_BASE = CFG_KEYS;

  localparam int CODE_DOWN_OFS = 1;
  localparam int CODE_UP_OFS   = 2;
  localparam int CODE_LONG_OFS = 3;

  localparam int NUM_SLOTS = 2 * NUM_KEYS;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int PTR_W     = $clog2(FIFO_DEPTH);
  localparam int CNT_W     = $clog2(FIFO_DEPTH + 1);

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_PUSH,
    BK_READ,
    BK_SEND
  } back_state_e;

  // one classified transaction handed from front to back
  typedef struct packed {
    action_e                         act;
    logic [NUM_SLOTS-1:0]            valid;
    logic [NUM_SLOTS-1:0][CODE_W-1:0] codes;
  } cmd_t;

endpackage

// ----- design/kdlr_front.sv -----
// front end: configuration, per-key debounce filters and event classification
module kdlr_front import kdlr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [NUM_KEYS-1:0]   key_levels_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output cmd_t                  q_cmd_o
);

  logic [FILT_W-1:0] fc_q [NUM_KEYS];
  logic [FILT_W-1:0] fc_d [NUM_KEYS];
  logic              pr_q [NUM_KEYS];
  logic              pr_d [NUM_KEYS];
  logic [LT_W-1:0]   lc_q [NUM_KEYS];
  logic [LT_W-1:0]   lc_d [NUM_KEYS];
  logic [RS_W-1:0]   rc_q [NUM_KEYS];
  logic [RS_W-1:0]   rc_d [NUM_KEYS];
  logic [LT_W-1:0]   lt_q [NUM_KEYS];
  logic [LT_W-1:0]   lt_d [NUM_KEYS];
  logic [RS_W-1:0]   rs_q [NUM_KEYS];
  logic [RS_W-1:0]   rs_d [NUM_KEYS];

  logic accept;
  logic tick;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign tick       = accept && (action_e'(action_i) == ACT_TICK);
  assign q_push_o   = accept;

  always_comb begin
    logic [LT_W-1:0] lc_inc;
    logic [RS_W-1:0] rc_inc;
    q_cmd_o.act   = action_e'(action_i);
    q_cmd_o.valid = '0;
    q_cmd_o.codes = '0;
    lc_inc        = '0;
    rc_inc        = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      fc_d[k] = fc_q[k];
      pr_d[k] = pr_q[k];
      lc_d[k] = lc_q[k];
      rc_d[k] = rc_q[k];
      lt_d[k] = lt_q[k];
      rs_d[k] = rs_q[k];
      lc_inc  = LT_W'(lc_q[k] + LT_W'(1));
      rc_inc  = RS_W'(rc_q[k] + RS_W'(1));
      if (tick) begin
        if (key_levels_i[k]) begin
          if (fc_q[k] < FILT_W'(FILTER_TICKS)) begin
            fc_d[k] = FILT_W'(FILTER_TICKS);
          end else if (fc_q[k] < FILT_W'(FILT_HI)) begin
            fc_d[k] = FILT_W'(fc_q[k] + FILT_W'(1));
          end else begin
            if (!pr_q[k]) begin
              pr_d[k]               = 1'b1;
              q_cmd_o.valid[2*k]    = 1'b1;
              q_cmd_o.codes[2*k]    = CODE_W'(3 * k + CODE_DOWN_OFS);
            end
            if (lt_q[k] != '0) begin
              if (lc_q[k] < lt_q[k]) begin
                lc_d[k] = lc_inc;
                if (lc_inc == lt_q[k]) begin
                  q_cmd_o.valid[2*k+1] = 1'b1;
                  q_cmd_o.codes[2*k+1] = CODE_W'(3 * k + CODE_LONG_OFS);
                end
              end else if (rs_q[k] != '0) begin
                if (rc_inc >= rs_q[k]) begin
                  rc_d[k]              = '0;
                  q_cmd_o.valid[2*k+1] = 1'b1;
                  q_cmd_o.codes[2*k+1] = CODE_W'(3 * k + CODE_DOWN_OFS);
                end else begin
                  rc_d[k] = rc_inc;
                end
              end
            end
          end
        end else begin
          if (fc_q[k] > FILT_W'(FILTER_TICKS)) begin
            fc_d[k] = FILT_W'(FILTER_TICKS);
          end else if (fc_q[k] != '0) begin
            fc_d[k] = FILT_W'(fc_q[k] - FILT_W'(1));
          end else if (pr_q[k]) begin
            pr_d[k]            = 1'b0;
            q_cmd_o.valid[2*k] = 1'b1;
            q_cmd_o.codes[2*k] = CODE_W'(3 * k + CODE_UP_OFS);
          end
          lc_d[k] = '0;
          rc_d[k] = '0;
        end
      end
      // register writes of a key also restart its repeat timing
      if (cfg_we_i && (k < CFG_KEYS)) begin
        if (cfg_index_i == CFG_IDX_W'(CFG_LONG_BASE + k)) begin
          lt_d[k] = cfg_data_i[LT_W-1:0];
          rc_d[k] = '0;
        end
        if (cfg_index_i == CFG_IDX_W'(CFG_REPEAT_BASE + k)) begin
          rs_d[k] = cfg_data_i[RS_W-1:0];
          rc_d[k] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        fc_q[k] <= FILT_W'(FILT_RESET);
        pr_q[k] <= 1'b0;
        lc_q[k] <= '0;
        rc_q[k] <= '0;
        lt_q[k] <= LT_W'(LT_RESET);
        rs_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        fc_q[k] <= fc_d[k];
        pr_q[k] <= pr_d[k];
        lc_q[k] <= lc_d[k];
        rc_q[k] <= rc_d[k];
        lt_q[k] <= lt_d[k];
        rs_q[k] <= rs_d[k];
      end
    end
  end

endmodule

// ----- design/kdlr_cmdq.sv -----
// short command queue between the front end and the event fifo engine
module kdlr_cmdq import kdlr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic head_valid_o,
  output cmd_t head_o,
  input  logic pop_i
);

  cmd_t                  entry_q [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wptr_q, wptr_d;
  logic [CMDQ_PTR_W-1:0] rptr_q, rptr_d;
  logic [CMDQ_CNT_W-1:0] cnt_q, cnt_d;
  logic                  do_push;
  logic                  do_pop;

  function automatic logic [CMDQ_PTR_W-1:0] wrap_inc(input logic [CMDQ_PTR_W-1:0] p);
    logic [CMDQ_PTR_W-1:0] r;
    if (p == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = CMDQ_PTR_W'(p + CMDQ_PTR_W'(1));
    end
    return r;
  endfunction

  assign full_o       = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = entry_q[rptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wptr_d = do_push ? wrap_inc(wptr_q) : wptr_q;
    rptr_d = do_pop ? wrap_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = CMDQ_CNT_W'(cnt_q + CMDQ_CNT_W'(1));
    end else if (do_pop && !do_push) begin
      cnt_d = CMDQ_CNT_W'(cnt_q - CMDQ_CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- design/kdlr_back.sv -----
// back end: event fifo with one write port, pop and clear, result register
module kdlr_back import kdlr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cmd_t              q_head_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CODE_W-1:0] key_code_o,
  output logic [CNT_W-1:0]  pending_o
);

  back_state_e       state_q, state_d;
  cmd_t              cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic [PTR_W-1:0]  rptr_q;
  logic [PTR_W-1:0]  wptr_q;
  logic [CNT_W-1:0]  count_q;
  logic [CODE_W-1:0] code_q;
  logic [CODE_W-1:0] rd_q;
  logic [CODE_W-1:0] mem [FIFO_DEPTH];

  logic do_push;
  logic do_pop;
  logic do_clear;
  logic load_code;
  logic last_slot;
  logic not_full;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = PTR_W'(p + PTR_W'(1));
    end
    return r;
  endfunction

  assign last_slot = (slot_q == SLOT_W'(NUM_SLOTS - 1));
  assign not_full  = (count_q < CNT_W'(FIFO_DEPTH));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          priority case (q_head_i.act)
            ACT_TICK: state_d = BK_PUSH;
            ACT_POP:  state_d = (count_q != '0) ? BK_READ : BK_SEND;
            default:  state_d = BK_SEND;
          endcase
        end
      end
      BK_PUSH: begin
        if (last_slot) begin
          state_d = BK_SEND;
        end
      end
      BK_READ: state_d = BK_SEND;
      BK_SEND: begin
        if (!out_stall_i) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o     = 1'b0;
    do_push     = 1'b0;
    do_pop      = 1'b0;
    do_clear    = 1'b0;
    load_code   = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        q_pop_o  = q_valid_i;
        do_pop   = q_valid_i && (q_head_i.act == ACT_POP) && (count_q != '0);
        do_clear = q_valid_i && (q_head_i.act == ACT_CLEAR);
      end
      BK_PUSH: do_push = cmd_q.valid[slot_q] && not_full;
      BK_READ: load_code = 1'b1;
      BK_SEND: out_valid_o = 1'b1;
      default: out_valid_o = 1'b0;
    endcase
  end

  assign key_code_o = code_q;
  assign pending_o  = count_q;

  // event store, read data registered
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wptr_q] <= cmd_q.codes[slot_q];
    end
    rd_q <= mem[rptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q  <= q_head_i;
      code_q <= '0;
    end else if (load_code) begin
      code_q <= rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
      slot_q  <= '0;
      rptr_q  <= '0;
      wptr_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        slot_q <= '0;
      end else if (state_q == BK_PUSH) begin
        slot_q <= SLOT_W'(slot_q + SLOT_W'(1));
      end
      if (do_push) begin
        wptr_q  <= ptr_inc(wptr_q);
        count_q <= CNT_W'(count_q + CNT_W'(1));
      end else if (do_pop) begin
        rptr_q  <= ptr_inc(rptr_q);
        count_q <= CNT_W'(count_q - CNT_W'(1));
      end else if (do_clear) begin
        rptr_q  <= wptr_q;
        count_q <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(FIFO_DEPTH))
    else $error("event fifo count above depth");

  a_push_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_PUSH) |=> (state_q == BK_PUSH || state_q == BK_SEND))
    else $error("push sequence left for a wrong state");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_clear |=> (count_q == '0 && rptr_q == wptr_q))
    else $error("clear did not empty the event fifo");

  a_pop_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> (state_q == BK_READ && count_q == CNT_W'($past(count_q) - CNT_W'(1))))
    else $error("pop did not move to read with one code less");
`endif

endmodule

// ----- design/key_debounce_long_repeat_fifo.sv -----
// key debounce with long press, auto repeat and event fifo: top level
// a transaction enters the command queue in the cycle it is accepted; the fifo engine
// then, one at a time, steps idle, a push per code slot, send for a tick; idle, read,
// send for a non-empty pop; idle, send for an empty pop, a clear or an unused action.
// send holds while the output stalls; ticks are slowed by the single write port of the
// event store walking every code slot. reset is asynchronous and active low: filters
// start at half the filter time, long times at 100 ticks, repeat off, event fifo empty.
module key_debounce_long_repeat_fifo import kdlr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [NUM_KEYS-1:0]   key_levels_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CODE_W-1:0]     key_code_o,
  output logic [CNT_W-1:0]      pending_o
);

  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_head_valid;
  cmd_t q_head;
  logic q_pop;

  kdlr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .key_levels_i (key_levels_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_cmd_o      (q_cmd)
  );

  kdlr_cmdq u_cmdq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .cmd_i        (q_cmd),
    .full_o       (q_full),
    .head_valid_o (q_head_valid),
    .head_o       (q_head),
    .pop_i        (q_pop)
  );

  kdlr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_head_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .key_code_o  (key_code_o),
    .pending_o   (pending_o)
  );

endmodule

// ----- tb/tb_key_debounce_long_repeat_fifo.sv -----
`timescale 1ns / 100ps
// self-checking testbench for the key debounce block with long press, repeat and event fifo
module tb_key_debounce_long_repeat_fifo;
  import kdlr_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int REG_BEYOND    = 2 * CFG_KEYS;
  localparam int SETTLE_CYCLES = 2 * NUM_KEYS + 8;
  localparam int MAX_GAP       = 16;

  typedef struct packed {
    logic [CODE_W-1:0] key_code;
    logic [CNT_W-1:0]  pending;
  } pop_report_t;

  typedef logic [NUM_KEYS-1:0][LT_W-1:0]       long_set_t;
  typedef logic [NUM_KEYS-1:0][CFG_DATA_W-1:0] speed_set_t;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  in_valid_i   = 1'b0;
  logic                  in_stall_o;
  logic [ACT_W-1:0]      action_i     = ACT_TICK;
  logic [NUM_KEYS-1:0]   key_levels_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i  = 1'b0;
  logic [CODE_W-1:0]     key_code_o;
  logic [CNT_W-1:0]      pending_o;

  // shadow of the key filters, timers, registers and event fifo
  logic [FILT_W-1:0] filt_cnt      [NUM_KEYS];
  logic              key_held      [NUM_KEYS];
  logic [LT_W-1:0]   hold_cnt      [NUM_KEYS];
  logic [RS_W-1:0]   rpt_cnt       [NUM_KEYS];
  logic [LT_W-1:0]   long_time_cfg [NUM_KEYS];
  logic [RS_W-1:0]   rpt_speed_cfg [NUM_KEYS];
  logic [CODE_W-1:0] event_fifo_model [$];
  pop_report_t       reports_due [$];

  int err_count = 0;
  bit steady    = 1'b0;

  always #10 clk_i = ~clk_i;

  key_debounce_long_repeat_fifo u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .key_levels_i (key_levels_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .key_code_o   (key_code_o),
    .pending_o    (pending_o)
  );

  function automatic int draw_gap();
    if (steady || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  // codes arriving at a full fifo are lost
  function automatic void push_event(input int code);
    if (event_fifo_model.size() < FIFO_DEPTH) event_fifo_model.push_back(CODE_W'(code));
  endfunction

  function automatic void debounce_key(input int k, input logic down);
    if (down) begin
      if (filt_cnt[k] < FILTER_TICKS) begin
        filt_cnt[k] = FILT_W'(FILTER_TICKS);
      end else if (filt_cnt[k] < FILT_HI) begin
        filt_cnt[k] = filt_cnt[k] + 1'b1;
      end else begin
        if (!key_held[k]) begin
          key_held[k] = 1'b1;
          push_event(3 * k + CODE_DOWN_OFS);
        end
        if (long_time_cfg[k] != 0) begin
          if (hold_cnt[k] < long_time_cfg[k]) begin
            hold_cnt[k] = hold_cnt[k] + 1'b1;
            if (hold_cnt[k] == long_time_cfg[k]) push_event(3 * k + CODE_LONG_OFS);
          end else if (rpt_speed_cfg[k] != 0) begin
            rpt_cnt[k] = rpt_cnt[k] + 1'b1;
            if (rpt_cnt[k] >= rpt_speed_cfg[k]) begin
              rpt_cnt[k] = '0;
              push_event(3 * k + CODE_DOWN_OFS);
            end
          end
        end
      end
    end else begin
      if (filt_cnt[k] > FILTER_TICKS) begin
        filt_cnt[k] = FILT_W'(FILTER_TICKS);
      end else if (filt_cnt[k] != 0) begin
        filt_cnt[k] = filt_cnt[k] - 1'b1;
      end else if (key_held[k]) begin
        key_held[k] = 1'b0;
        push_event(3 * k + CODE_UP_OFS);
      end
      hold_cnt[k] = '0;
      rpt_cnt[k]  = '0;
    end
  endfunction

  function automatic pop_report_t process_item(input logic [ACT_W-1:0] act,
                                               input logic [NUM_KEYS-1:0] lv);
    pop_report_t rep;
    rep.key_code = '0;
    case (act)
      ACT_TICK: begin
        for (int k = 0; k < NUM_KEYS; k++) debounce_key(k, lv[k]);
      end
      ACT_POP: begin
        if (event_fifo_model.size() != 0) rep.key_code = event_fifo_model.pop_front();
      end
      ACT_CLEAR: begin
        event_fifo_model.delete();
      end
      default: ;
    endcase
    rep.pending = CNT_W'(event_fifo_model.size());
    return rep;
  endfunction

  // valid is left high after acceptance so that back-to-back transactions need one update
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [NUM_KEYS-1:0] lv);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    key_levels_i <= lv;
    do @(posedge clk_i); while (in_stall_o);
    reports_due.push_back(process_item(act, lv));
  endtask

  task automatic wait_all_reported();
    in_valid_i <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] value);
    int k;
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_IDX_W'(idx);
    cfg_data_i  <= value;
    @(posedge clk_i);
    if (idx >= CFG_LONG_BASE && idx < CFG_LONG_BASE + CFG_KEYS) begin
      k = idx - CFG_LONG_BASE;
      if (k < NUM_KEYS) begin
        long_time_cfg[k] = value[LT_W-1:0];
        rpt_cnt[k]       = '0;
      end
    end else if (idx >= CFG_REPEAT_BASE && idx < CFG_REPEAT_BASE + CFG_KEYS) begin
      k = idx - CFG_REPEAT_BASE;
      if (k < NUM_KEYS) begin
        rpt_speed_cfg[k] = value[RS_W-1:0];
        rpt_cnt[k]       = '0;
      end
    end
  endtask

  task automatic program_keys(input long_set_t lt, input speed_set_t rs);
    wait_all_reported();
    for (int k = 0; k < NUM_KEYS; k++) begin
      write_reg(CFG_LONG_BASE + k, lt[k]);
      write_reg(CFG_REPEAT_BASE + k, rs[k]);
    end
    // indexes past the register list must be ignored
    write_reg(REG_BEYOND, CFG_DATA_W'($urandom));
    write_reg(REG_BEYOND + 1, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_basic_actions();
    send_item(ACT_POP, '0);
    send_item(ACT_CLEAR, '1);
    send_item(ACT_UNUSED, '1);
    send_item(ACT_TICK, '0);
    // all keys qualify in the same tick, codes in key order
    repeat (7) send_item(ACT_TICK, '1);
    send_item(ACT_POP, '0);
    send_item(ACT_UNUSED, '0);
    send_item(ACT_CLEAR, '0);
    repeat (7) send_item(ACT_TICK, '0);
    repeat (4) send_item(ACT_POP, '0);
  endtask

  task automatic test_long_and_repeat();
    long_set_t  lt;
    speed_set_t rs;
    lt[0] = 16'd1;
    rs[0] = 16'd1;
    lt[1] = 16'd3;
    rs[1] = 16'd2;
    lt[2] = 16'd0;
    rs[2] = 16'hffff;
    program_keys(lt, rs);
    // key 0 sends down then long in the qualifying tick
    repeat (16) begin
      send_item(ACT_TICK, '1);
      send_item(ACT_POP, '0);
    end
    repeat (8) send_item(ACT_TICK, '0);
    repeat (6) send_item(ACT_POP, '0);
  endtask

  task automatic test_fifo_overflow();
    long_set_t  lt;
    speed_set_t rs;
    lt = {NUM_KEYS{16'd1}};
    rs = {NUM_KEYS{16'd1}};
    program_keys(lt, rs);
    steady = 1'b1;
    repeat (20) send_item(ACT_TICK, '1);
    repeat (FIFO_DEPTH + 2) send_item(ACT_POP, '0);
    steady = 1'b0;
    repeat (10) send_item(ACT_TICK, '1);
    send_item(ACT_CLEAR, '0);
    repeat (8) send_item(ACT_TICK, '0);
    repeat (4) send_item(ACT_POP, '0);
  endtask

  task automatic test_long_time_lowered();
    long_set_t  lt;
    speed_set_t rs;
    lt = {NUM_KEYS{16'd20}};
    rs = '0;
    program_keys(lt, rs);
    repeat (22) begin
      send_item(ACT_TICK, NUM_KEYS'(1));
      send_item(ACT_POP, '0);
    end
    // key 0 is still held past the new long time: no long code, repeats follow
    wait_all_reported();
    write_reg(CFG_LONG_BASE, 16'd5);
    write_reg(CFG_REPEAT_BASE, 16'd3);
    cfg_we_i <= 1'b0;
    repeat (12) begin
      send_item(ACT_TICK, NUM_KEYS'(1));
      send_item(ACT_POP, '0);
    end
    // rewriting the speed mid-hold restarts the repeat timer
    wait_all_reported();
    write_reg(CFG_REPEAT_BASE, 16'd4);
    cfg_we_i <= 1'b0;
    repeat (10) begin
      send_item(ACT_TICK, NUM_KEYS'(1));
      send_item(ACT_POP, '0);
    end
    repeat (8) send_item(ACT_TICK, '0);
    repeat (4) send_item(ACT_POP, '0);
  endtask

  task automatic test_slow_repeat();
    long_set_t  lt;
    speed_set_t rs;
    lt = {NUM_KEYS{16'd1}};
    rs = {NUM_KEYS{16'hff00}};  // upper byte only, so repeat stays off
    rs[NUM_KEYS-1] = 16'hffff;
    program_keys(lt, rs);
    for (int i = 0; i < 270; i++) begin
      send_item(ACT_TICK, NUM_KEYS'(1) << (NUM_KEYS - 1));
      if (i % 10 == 9) send_item(ACT_POP, '0);
    end
    repeat (8) send_item(ACT_TICK, '0);
    repeat (6) send_item(ACT_POP, '0);
  endtask

  // runs of steady key levels with pops mixed in, plus bouncing runs and stray actions
  task automatic run_traffic(input int n_items, input int pop_pct);
    int                  sent;
    int                  run_len;
    bit                  bouncy;
    logic [NUM_KEYS-1:0] lv;
    sent = 0;
    while (sent < n_items) begin
      lv      = NUM_KEYS'($urandom);
      run_len = $urandom_range(1, 30);
      bouncy  = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 15) == 0) steady = ~steady;
      for (int i = 0; i < run_len; i++) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < pop_pct) begin
          send_item(ACT_POP, NUM_KEYS'($urandom));
        end else if (pick < pop_pct + 3) begin
          send_item(ACT_CLEAR, NUM_KEYS'($urandom));
        end else if (pick < pop_pct + 5) begin
          send_item(ACT_UNUSED, NUM_KEYS'($urandom));
        end else begin
          send_item(ACT_TICK, bouncy ? NUM_KEYS'($urandom) : lv);
        end
        sent++;
      end
      if ($urandom_range(0, 24) == 0) wait_all_reported();
    end
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    long_set_t  lt;
    speed_set_t rs;
    for (int phase = 0; phase < 6; phase++) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        case (phase)
          0: begin
            lt[k] = LT_W'(LT_RESET);
            rs[k] = '0;
          end
          1: begin
            lt[k] = LT_W'($urandom_range(1, 12));
            rs[k] = CFG_DATA_W'($urandom_range(1, 4));
          end
          2: begin
            lt[k] = '0;
            rs[k] = CFG_DATA_W'(255);
          end
          3: begin
            lt[k] = '1;
            rs[k] = '0;
          end
          4: begin
            lt[k] = LT_W'(1);
            rs[k] = CFG_DATA_W'(1);
          end
          default: begin
            lt[k] = LT_W'($urandom_range(0, 30));
            rs[k] = CFG_DATA_W'($urandom);
          end
        endcase
      end
      program_keys(lt, rs);
      run_traffic(60, (phase == 4) ? 55 : 35);
    end
  endtask

  initial begin : result_stall
    int hold;
    @(posedge rst_ni);
    forever begin
      hold = draw_gap();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  always @(posedge clk_i) begin : check_results
    pop_report_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reports_due.size() == 0) begin
        $error("unexpected transaction: key_code %0d pending %0d", key_code_o, pending_o);
        err_count++;
      end else begin
        due = reports_due.pop_front();
        if (key_code_o !== due.key_code) begin
          $error("key_code: expected %0d, got %0d", due.key_code, key_code_o);
          err_count++;
        end
        if (pending_o !== due.pending) begin
          $error("pending: expected %0d, got %0d", due.pending, pending_o);
          err_count++;
        end
      end
    end
  end

  initial begin : run_limit
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      filt_cnt[k]      = FILT_W'(FILT_RESET);
      key_held[k]      = 1'b0;
      hold_cnt[k]      = '0;
      rpt_cnt[k]       = '0;
      long_time_cfg[k] = LT_W'(LT_RESET);
      rpt_speed_cfg[k] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_basic_actions();
    test_long_and_repeat();
    test_fifo_overflow();
    test_long_time_lowered();
    test_slow_repeat();
    test_random_traffic();

    wait_all_reported();
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- key_debounce_long_repeat_fifo.f -----
design/kdlr_pkg.sv
design/kdlr_front.sv
design/kdlr_cmdq.sv
design/kdlr_back.sv
design/key_debounce_long_repeat_fifo.sv
tb/tb_key_debounce_long_repeat_fifo.sv
